// ===== hw/rtl/tssc_pkg.sv =====
package tssc_pkg;

   // sample and field widths
   localparam int SAMPLE_W  = 10;
   localparam int YPOS_W    = 11;
   localparam int PRESS_W   = 21;
   localparam int DELAY_W   = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 10;

   // pressure arithmetic
   localparam logic [9:0] PRESS_KX = 10'd685;
   localparam logic [7:0] PRESS_KZ = 8'd159;
   localparam int P1_W    = 20;             // 685 * x
   localparam int P2_W    = 18;             // 159 * z
   localparam int PROD_W  = 30;             // each full product
   localparam int DIVD_W  = PROD_W - 10;    // magnitude after the /1024 shift
   localparam int DIV_STEPS = DIVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // low byte bit fields
   localparam int LSB_PEN_BIT = 6;

   // register reset values
   localparam logic [9:0] Y_MIN_RST    = 10'd40;
   localparam logic [9:0] Y_MAX_RST    = 10'd980;
   localparam logic [9:0] INTERVAL_RST = 10'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_Y   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_MAX    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = 2'd3;

   // request kinds
   localparam logic [1:0] REQ_PEN_DOWN   = 2'd0;
   localparam logic [1:0] REQ_DATA_READY = 2'd1;
   localparam logic [1:0] REQ_SCAN_TIMER = 2'd2;

   // scan modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_ACTIVE  = 2'd1;
   localparam logic [1:0] MODE_SCAN    = 2'd2;
   localparam logic [1:0] MODE_SCAN_LP = 2'd3;

   // touch event codes
   localparam logic [1:0] TEV_NONE    = 2'd0;
   localparam logic [1:0] TEV_PRESS   = 2'd1;
   localparam logic [1:0] TEV_RELEASE = 2'd2;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL1 = 6'b000010,
      ST_MUL2 = 6'b000100,
      ST_SUB  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic sub;
      logic div_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/touch_sample_scan_controller_core.sv =====
// Sequence: from request acceptance through two multiply stages, sign/magnitude,
//   20 divider steps and output load to response valid.
// Flow: one transaction in flight at a time, dominated by the 20-step divider by z;
//   a held response delays the next acceptance.
// Reset: synchronous active high; clears pen state, scan mode (idle low power),
//   configuration to flip_y 0, y_min 40, y_max 980, interval 10 ms.
module touch_sample_scan_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tssc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tssc_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [7:0]                          req_x_high,
   input  logic [7:0]                          req_y_high,
   input  logic [7:0]                          req_z_high,
   input  logic [7:0]                          req_low_bits,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_position_valid,
   output logic [tssc_pkg::SAMPLE_W-1:0]       rsp_x_pos,
   output logic [tssc_pkg::YPOS_W-1:0]         rsp_y_pos,
   output logic signed [tssc_pkg::PRESS_W-1:0] rsp_pressure,
   output logic [1:0]                          rsp_touch_event,
   output logic                                rsp_touching,
   output logic                                rsp_power_active,
   output logic [tssc_pkg::DELAY_W-1:0]        rsp_timer_delay_ms,
   output logic                                rsp_event_ignored
);

   tssc_pkg::cmd_type    cmd;
   tssc_pkg::status_type status;

   tssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tssc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_x_high         (req_x_high),
      .req_y_high         (req_y_high),
      .req_z_high         (req_z_high),
      .req_low_bits       (req_low_bits),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_position_valid (rsp_position_valid),
      .rsp_x_pos          (rsp_x_pos),
      .rsp_y_pos          (rsp_y_pos),
      .rsp_pressure       (rsp_pressure),
      .rsp_touch_event    (rsp_touch_event),
      .rsp_touching       (rsp_touching),
      .rsp_power_active   (rsp_power_active),
      .rsp_timer_delay_ms (rsp_timer_delay_ms),
      .rsp_event_ignored  (rsp_event_ignored)
   );

   // one transaction in flight: busy right after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   // masked events report nothing and arm no timer
   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_ignored) |->
         (!rsp_position_valid && rsp_timer_delay_ms == '0 &&
          rsp_touch_event == tssc_pkg::TEV_NONE))
      else $error("ignored event carries data");

   // release leaves the pen up with zero pressure
   a_release_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_touch_event == tssc_pkg::TEV_RELEASE) |->
         (!rsp_touching && rsp_pressure == '0))
      else $error("release with pen still down or nonzero pressure");

   // pressure only accompanies a reported position
   a_pressure_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_position_valid) |-> (rsp_pressure == '0))
      else $error("pressure without position");

endmodule

// ===== hw/rtl/tssc_ctrl.sv =====
module tssc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tssc_pkg::status_type status,
   output tssc_pkg::cmd_type    cmd
);

   tssc_pkg::state_type state_ff, state_in;
   logic [tssc_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic div_last;

   assign req_ready = (state_ff == tssc_pkg::ST_IDLE);
   assign div_last  = (div_cnt_ff == tssc_pkg::DIV_CNT_W'(tssc_pkg::DIV_STEPS - 1));

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      cmd          = '0;
      case (state_ff)
         tssc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = tssc_pkg::ST_MUL1;
            end
         end
         tssc_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = tssc_pkg::ST_MUL2;
         end
         tssc_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = tssc_pkg::ST_SUB;
         end
         tssc_pkg::ST_SUB: begin
            cmd.sub    = 1'b1;
            div_cnt_in = '0;
            state_in   = tssc_pkg::ST_DIV;
         end
         tssc_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_last) begin
               state_in = tssc_pkg::ST_DONE;
            end
         end
         tssc_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = tssc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tssc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tssc_pkg::ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

// ===== hw/rtl/tssc_dp.sv =====
module tssc_dp (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [tssc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tssc_pkg::CSR_DAT_W-1:0]      csr_wdata,
   // request payload
   input  logic [1:0]                          req_type,
   input  logic [7:0]                          req_x_high,
   input  logic [7:0]                          req_y_high,
   input  logic [7:0]                          req_z_high,
   input  logic [7:0]                          req_low_bits,
   // control
   input  tssc_pkg::cmd_type                   cmd,
   output tssc_pkg::status_type                status,
   // response
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_position_valid,
   output logic [tssc_pkg::SAMPLE_W-1:0]       rsp_x_pos,
   output logic [tssc_pkg::YPOS_W-1:0]         rsp_y_pos,
   output logic signed [tssc_pkg::PRESS_W-1:0] rsp_pressure,
   output logic [1:0]                          rsp_touch_event,
   output logic                                rsp_touching,
   output logic                                rsp_power_active,
   output logic [tssc_pkg::DELAY_W-1:0]        rsp_timer_delay_ms,
   output logic                                rsp_event_ignored
);

   localparam int SW = tssc_pkg::SAMPLE_W;

   // configuration registers
   logic          flip_y_ff;
   logic [SW-1:0] y_min_ff, y_max_ff, interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_y_ff   <= 1'b0;
         y_min_ff    <= tssc_pkg::Y_MIN_RST;
         y_max_ff    <= tssc_pkg::Y_MAX_RST;
         interval_ff <= tssc_pkg::INTERVAL_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            tssc_pkg::CSR_FLIP_Y:   flip_y_ff   <= csr_wdata[0];
            tssc_pkg::CSR_Y_MIN:    y_min_ff    <= csr_wdata;
            tssc_pkg::CSR_Y_MAX:    y_max_ff    <= csr_wdata;
            tssc_pkg::CSR_INTERVAL: interval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sample unpacking
   logic [SW-1:0] x_s, y_s, z_s;
   assign x_s = {req_x_high, req_low_bits[1:0]};
   assign y_s = {req_y_high, req_low_bits[3:2]};
   assign z_s = {req_z_high, req_low_bits[5:4]};

   // y mirror with clamp to y_min
   logic signed [11:0] y_mir;
   logic [tssc_pkg::YPOS_W-1:0] y_rep;
   assign y_mir = $signed({2'b00, y_min_ff}) + $signed({2'b00, y_max_ff})
                  - $signed({2'b00, y_s});
   always_comb begin
      if (!flip_y_ff) begin
         y_rep = {1'b0, y_s};
      end else if (y_mir[11]) begin
         y_rep = {1'b0, y_min_ff};
      end else begin
         y_rep = y_mir[10:0];
      end
   end

   // pen and mode state
   logic       pen_ff, pen_in;
   logic [1:0] mode_ff, mode_in;
   logic       ev_accept;
   logic [SW-1:0] interval;
   logic       e_valid, e_ign;
   logic [1:0] e_tev;
   logic [tssc_pkg::DELAY_W-1:0] e_delay;

   assign interval = (interval_ff == '0) ? SW'(1) : interval_ff;

   // event decode and mode transitions
   always_comb begin
      case (req_type)
         tssc_pkg::REQ_PEN_DOWN:
            ev_accept = mode_ff inside {tssc_pkg::MODE_IDLE, tssc_pkg::MODE_SCAN_LP};
         tssc_pkg::REQ_DATA_READY:
            ev_accept = mode_ff inside {tssc_pkg::MODE_IDLE, tssc_pkg::MODE_ACTIVE};
         tssc_pkg::REQ_SCAN_TIMER:
            ev_accept = mode_ff inside {tssc_pkg::MODE_SCAN, tssc_pkg::MODE_SCAN_LP};
         default:
            ev_accept = 1'b0;
      endcase

      e_valid = 1'b0;
      e_ign   = 1'b0;
      e_tev   = tssc_pkg::TEV_NONE;
      e_delay = '0;
      pen_in  = pen_ff;
      mode_in = mode_ff;
      if (!ev_accept) begin
         e_ign = 1'b1;
      end else if (req_type == tssc_pkg::REQ_PEN_DOWN) begin
         mode_in = (mode_ff == tssc_pkg::MODE_IDLE) ? tssc_pkg::MODE_ACTIVE
                                                    : tssc_pkg::MODE_SCAN;
      end else if (req_low_bits[tssc_pkg::LSB_PEN_BIT]) begin
         e_valid = 1'b1;
         if (!pen_ff) begin
            e_tev  = tssc_pkg::TEV_PRESS;
            pen_in = 1'b1;
         end
         if (req_type == tssc_pkg::REQ_DATA_READY) begin
            e_delay = {interval, 1'b0};
            mode_in = (mode_ff == tssc_pkg::MODE_IDLE) ? tssc_pkg::MODE_SCAN_LP
                                                       : tssc_pkg::MODE_SCAN;
         end else begin
            e_delay = {1'b0, interval};
         end
      end else begin
         if (pen_ff) begin
            e_tev  = tssc_pkg::TEV_RELEASE;
            pen_in = 1'b0;
         end
         mode_in = tssc_pkg::MODE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff  <= 1'b0;
         mode_ff <= tssc_pkg::MODE_IDLE;
      end else if (cmd.load) begin
         pen_ff  <= pen_in;
         mode_ff <= mode_in;
      end
   end

   // pending transaction fields
   logic                         p_valid_ff, p_ign_ff, p_pen_ff, p_power_ff;
   logic [1:0]                   p_tev_ff;
   logic [SW-1:0]                p_x_ff;
   logic [tssc_pkg::YPOS_W-1:0]  p_y_ff;
   logic [tssc_pkg::DELAY_W-1:0] p_delay_ff;
   logic [SW-1:0]                x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_valid_ff <= e_valid;
         p_ign_ff   <= e_ign;
         p_pen_ff   <= pen_in;
         p_power_ff <= (mode_in == tssc_pkg::MODE_ACTIVE) ||
                       (mode_in == tssc_pkg::MODE_SCAN);
         p_tev_ff   <= e_tev;
         p_x_ff     <= e_valid ? x_s : '0;
         p_y_ff     <= e_valid ? y_rep : '0;
         p_delay_ff <= e_delay;
         x_ff       <= x_s;
         y_ff       <= y_s;
         z_ff       <= z_s;
      end
   end

   // first multiply stage: constant scaling and complements
   logic [tssc_pkg::P1_W-1:0] p1_ff;
   logic [tssc_pkg::P2_W-1:0] p2_ff;
   logic [10:0]               d1_ff, d2_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         p1_ff <= {10'd0, x_ff} * {10'd0, tssc_pkg::PRESS_KX};
         p2_ff <= {8'd0, z_ff} * {10'd0, tssc_pkg::PRESS_KZ};
         d1_ff <= 11'd1024 - {1'b0, z_ff};
         d2_ff <= 11'd1024 - {1'b0, y_ff};
      end
   end

   // second multiply stage
   logic [30:0] m1;
   logic [28:0] m2;
   logic [tssc_pkg::PROD_W-1:0] prod1_ff, prod2_ff;

   assign m1 = {11'd0, p1_ff} * {20'd0, d1_ff};
   assign m2 = {11'd0, p2_ff} * {18'd0, d2_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul2) begin
         prod1_ff <= m1[tssc_pkg::PROD_W-1:0];
         prod2_ff <= {1'b0, m2};
      end
   end

   // difference, sign and magnitude over 1024
   logic [30:0] diff, mag;
   assign diff = {1'b0, prod1_ff} - {1'b0, prod2_ff};
   assign mag  = diff[30] ? (31'd0 - diff) : diff;

   // restoring divider by z, one quotient bit a step
   logic                           neg_ff;
   logic [SW-1:0]                  rem_ff;
   logic [tssc_pkg::DIVD_W-1:0]    dq_ff;
   logic [SW:0]                    rem_sh, rem_sub;
   logic                           q_bit;

   assign rem_sh  = {rem_ff, dq_ff[tssc_pkg::DIVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, z_ff};
   assign q_bit   = (rem_sh >= {1'b0, z_ff});

   always_ff @(posedge clock) begin
      if (cmd.sub) begin
         neg_ff <= diff[30];
         rem_ff <= '0;
         dq_ff  <= mag[tssc_pkg::PROD_W-1:10];
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
         dq_ff  <= {dq_ff[tssc_pkg::DIVD_W-2:0], q_bit};
      end
   end

   // signed pressure, zero without a sample or with z zero
   logic signed [tssc_pkg::PRESS_W-1:0] press;
   always_comb begin
      if (!p_valid_ff || (z_ff == '0)) begin
         press = '0;
      end else if (neg_ff) begin
         press = $signed(21'd0 - {1'b0, dq_ff});
      end else begin
         press = $signed({1'b0, dq_ff});
      end
   end

   // output register
   logic rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_position_valid <= p_valid_ff;
         rsp_x_pos          <= p_x_ff;
         rsp_y_pos          <= p_y_ff;
         rsp_pressure       <= press;
         rsp_touch_event    <= p_tev_ff;
         rsp_touching       <= p_pen_ff;
         rsp_power_active   <= p_power_ff;
         rsp_timer_delay_ms <= p_delay_ff;
         rsp_event_ignored  <= p_ign_ff;
      end
   end

endmodule
